FILE: hw/rtl/gesa_pkg.sv
// ----------------------------------------------------------------------------
// gesa_pkg: shared definitions for the graded event spectrum accumulator
// Field widths, request/grade/register codes, word and command types, and
// the grade selection function used by the front end.
// ----------------------------------------------------------------------------
`default_nettype none

package gesa_pkg;

    // Field widths
    localparam int HEIGHT_W  = 20;
    localparam int WIDTH_W   = 16;
    localparam int GRADE_W   = 3;
    localparam int REQ_W     = 2;
    localparam int RANK_W    = 4;
    localparam int WEIGHT_W  = 4;
    localparam int SEL_W     = 11;
    localparam int HIT_W     = 11;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    // Default histogram size (regular bins, without underflow/overflow)
    localparam int NUM_BINS_DEF = 1024;

    // Quotient bits retired per divider cycle
    localparam int DIV_BITS = 4;

    // Command queue depth between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_EVENT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PEAK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Grade mode codes
    localparam logic [GRADE_W-1:0] GRADE_GOOD     = 3'd0;
    localparam logic [GRADE_W-1:0] GRADE_SINGLE   = 3'd1;
    localparam logic [GRADE_W-1:0] GRADE_DOUBLE   = 3'd2;
    localparam logic [GRADE_W-1:0] GRADE_EXTENDED = 3'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRADE_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 3'd4;

    // Input word
    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [HEIGHT_W-1:0] pulse_height;
        logic [RANK_W-1:0]   event_rank;
        logic [WEIGHT_W-1:0] pixel_weight;
        logic [HEIGHT_W-1:0] range_lo;
        logic [HEIGHT_W-1:0] range_hi;
        logic [SEL_W-1:0]    bin_select;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic                accepted;
        logic [HIT_W-1:0]    bin_hit;
        logic [HEIGHT_W-1:0] peak_position;
        logic [COUNT_W-1:0]  count_value;
    } t_out_word;

    // Configuration register set
    typedef struct packed {
        logic [HEIGHT_W-1:0] height_min;
        logic [HEIGHT_W-1:0] height_max;
        logic [GRADE_W-1:0]  grade_mode;
        logic [HEIGHT_W-1:0] bin_origin;
        logic [WIDTH_W-1:0]  bin_width;
    } t_cfg;

    // Classified command kinds
    typedef enum logic [1:0] {
        KIND_DIRECT,    // result known up front, no store access
        KIND_HIT,       // accepted event, bump its bin
        KIND_PEAK,      // peak search over a non-empty range
        KIND_READ       // read one bin inside the store
    } t_cmd_kind;

    // Command passed from front to back
    typedef struct packed {
        t_cmd_kind           kind;
        logic [HEIGHT_W-1:0] a;     // height, range low, or direct position
        logic [HEIGHT_W-1:0] b;     // range high
        logic [SEL_W-1:0]    sel;   // bin to read
    } t_cmd;

    // Grade selection
    function automatic logic grade_ok(
        input logic [GRADE_W-1:0]  mode,
        input logic [RANK_W-1:0]   rank,
        input logic [WEIGHT_W-1:0] weight
    );
        logic ok;
        case (mode)
            GRADE_GOOD:     ok = (rank <= RANK_W'(1));
            GRADE_SINGLE:   ok = (rank == RANK_W'(0));
            GRADE_DOUBLE:   ok = (rank == RANK_W'(1)) && (weight == WEIGHT_W'(2));
            GRADE_EXTENDED: ok = (rank == RANK_W'(1)) && (weight >= WEIGHT_W'(3));
            default:        ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gesa_front.sv
// ----------------------------------------------------------------------------
// gesa_front: input acceptance and request classification
// Checks the height window and grade of events, the order of peak ranges
// and the reach of bin reads, and pushes one command per input word.
// ----------------------------------------------------------------------------
`default_nettype none

module gesa_front #(
    parameter int NUM_BINS = gesa_pkg::NUM_BINS_DEF
) (
    input  wire logic              i_in_valid,
    input  wire gesa_pkg::t_in_word i_in_word,
    output logic                   o_in_ready,
    input  wire gesa_pkg::t_cfg    i_cfg,
    input  wire logic              i_fifo_full,
    input  wire logic              i_clearing,
    output logic                   o_push,
    output gesa_pkg::t_cmd         o_cmd
);
    import gesa_pkg::*;

    localparam int DEPTH = NUM_BINS + 2;

    logic c_in_window;
    logic c_grade;
    logic c_sel_ok;

    // Take a word whenever the queue has room and the store is ready
    assign o_in_ready = !i_fifo_full && !i_clearing;
    assign o_push     = i_in_valid && o_in_ready;

    assign c_in_window = (i_in_word.pulse_height >= i_cfg.height_min) &&
                         (i_in_word.pulse_height <= i_cfg.height_max);
    assign c_grade     = grade_ok(i_cfg.grade_mode, i_in_word.event_rank,
                                  i_in_word.pixel_weight);
    assign c_sel_ok    = (32'(i_in_word.bin_select) < 32'(DEPTH));

    // Classify the request
    always_comb begin
        o_cmd.kind = KIND_DIRECT;
        o_cmd.a    = '0;
        o_cmd.b    = i_in_word.range_hi;
        o_cmd.sel  = i_in_word.bin_select;
        case (i_in_word.req_type)
            REQ_EVENT: begin
                if (c_in_window && c_grade) begin
                    o_cmd.kind = KIND_HIT;
                    o_cmd.a    = i_in_word.pulse_height;
                end
            end
            REQ_PEAK: begin
                // reversed range answers with range_lo and no count
                o_cmd.a = i_in_word.range_lo;
                if (i_in_word.range_lo <= i_in_word.range_hi) begin
                    o_cmd.kind = KIND_PEAK;
                end
            end
            REQ_READ: begin
                if (c_sel_ok) begin
                    o_cmd.kind = KIND_READ;
                end
            end
            default: begin
                o_cmd.kind = KIND_DIRECT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gesa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gesa_cmd_fifo: short command queue between front and back
// Lets the front take new words while the back is busy with the store.
// ----------------------------------------------------------------------------
`default_nettype none

module gesa_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gesa_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output gesa_pkg::t_cmd      o_cmd,
    output logic                o_valid,
    output logic                o_full
);
    import gesa_pkg::*;

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    t_cmd             r_slot [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(CMD_FIFO_DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gesa_divider.sv
// ----------------------------------------------------------------------------
// gesa_divider: iterative unsigned divider for bin index computation
// Restoring division of a height offset by the bin width, a few quotient
// bits per cycle. Quotient and remainder hold after the done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module gesa_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [gesa_pkg::HEIGHT_W-1:0] i_dividend,
    input  wire logic [gesa_pkg::WIDTH_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic      [gesa_pkg::HEIGHT_W-1:0] o_quo,
    output logic      [gesa_pkg::WIDTH_W-1:0]  o_rem
);
    import gesa_pkg::*;

    localparam int DIV_STEPS = HEIGHT_W / DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [HEIGHT_W-1:0] r_quo;
    logic [WIDTH_W-1:0]  r_rem;
    logic [WIDTH_W-1:0]  r_den;
    logic [HEIGHT_W-1:0] c_quo;
    logic [WIDTH_W-1:0]  c_rem;
    logic [WIDTH_W:0]    c_ext;

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    // DIV_BITS restoring steps per cycle, dividend shifts out of r_quo
    always_comb begin
        c_quo = r_quo;
        c_rem = r_rem;
        c_ext = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            c_ext = {c_rem, c_quo[HEIGHT_W-1]};
            c_quo = {c_quo[HEIGHT_W-2:0], 1'b0};
            if (c_ext >= {1'b0, r_den}) begin
                c_ext    = c_ext - {1'b0, r_den};
                c_quo[0] = 1'b1;
            end
            c_rem = c_ext[WIDTH_W-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= c_quo;
            r_rem <= c_rem;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gesa_back.sv
// ----------------------------------------------------------------------------
// gesa_back: command execution against the bin count memory
// Clears the memory after reset, bumps bins for accepted events, scans bin
// ranges for the peak, reads single bins, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gesa_back #(
    parameter int NUM_BINS = gesa_pkg::NUM_BINS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gesa_pkg::t_cfg      i_cfg,
    input  wire logic                i_cmd_valid,
    input  wire gesa_pkg::t_cmd      i_cmd,
    output logic                     o_pop,
    output logic                     o_clearing,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output gesa_pkg::t_out_word      o_out_word
);
    import gesa_pkg::*;

    localparam int DEPTH = NUM_BINS + 2;
    localparam int BIN_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EV_DIV,
        S_EV_WR,
        S_RD_OUT,
        S_PK_LO,
        S_PK_HI,
        S_PK_SCAN,
        S_PK_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [BIN_W-1:0]    r_addr, n_addr;
    logic [BIN_W-1:0]    r_bin, n_bin;
    logic [BIN_W-1:0]    r_bhi, n_bhi;
    logic [HEIGHT_W-1:0] r_lo, n_lo;
    logic [HEIGHT_W-1:0] r_hi, n_hi;
    logic [HEIGHT_W-1:0] r_edge, n_edge;
    logic [HEIGHT_W-1:0] r_pos, n_pos;
    logic [HEIGHT_W-1:0] r_pipe_edge, n_pipe_edge;
    logic [COUNT_W-1:0]  r_best, n_best;
    logic                r_first, n_first;
    logic                r_pipe_vld, n_pipe_vld;
    logic                r_pipe_first, n_pipe_first;
    logic                r_out_vld, n_out_vld;
    t_out_word           r_out_word, n_out_word;

    // Count memory
    logic [COUNT_W-1:0]  r_mem [DEPTH];
    logic [COUNT_W-1:0]  r_rd_data;
    logic                c_rd_en;
    logic [BIN_W-1:0]    c_rd_addr;
    logic                c_wr_en;
    logic [BIN_W-1:0]    c_wr_addr;
    logic [COUNT_W-1:0]  c_wr_data;

    // Divider hookup
    logic                c_div_start;
    logic [HEIGHT_W-1:0] c_div_dividend;
    logic                w_div_done;
    logic [HEIGHT_W-1:0] w_div_quo;
    logic [WIDTH_W-1:0]  w_div_rem;

    logic [WIDTH_W-1:0]  c_width;
    logic [BIN_W-1:0]    c_div_bin;
    logic                c_out_free;
    logic [COUNT_W-1:0]  c_cmp_best;
    logic [HEIGHT_W-1:0] c_cmp_pos;

    gesa_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_div_start),
        .i_dividend (c_div_dividend),
        .i_divisor  (c_width),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    // Zero width behaves as one
    assign c_width = (i_cfg.bin_width == '0) ? WIDTH_W'(1) : i_cfg.bin_width;

    // Bin from quotient, everything past the last regular bin is overflow
    assign c_div_bin = (w_div_quo >= HEIGHT_W'(NUM_BINS)) ? BIN_W'(NUM_BINS + 1)
                                                           : BIN_W'(w_div_quo) + 1'b1;

    assign c_out_free  = !r_out_vld || i_out_ready;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // Peak compare stage: first strictly larger count wins
    always_comb begin
        c_cmp_best = r_best;
        c_cmp_pos  = r_pos;
        if (r_pipe_vld && (r_rd_data > r_best)) begin
            c_cmp_best = r_rd_data;
            c_cmp_pos  = r_pipe_first ? r_lo : r_pipe_edge;
        end
    end

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_bin          = r_bin;
        n_bhi          = r_bhi;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_edge         = r_edge;
        n_pos          = c_cmp_pos;
        n_best         = c_cmp_best;
        n_first        = r_first;
        n_pipe_vld     = 1'b0;
        n_pipe_first   = r_pipe_first;
        n_pipe_edge    = r_pipe_edge;
        n_out_vld      = r_out_vld && !i_out_ready;
        n_out_word     = r_out_word;
        o_pop          = 1'b0;
        c_rd_en        = 1'b0;
        c_rd_addr      = r_addr;
        c_wr_en        = 1'b0;
        c_wr_addr      = r_addr;
        c_wr_data      = '0;
        c_div_start    = 1'b0;
        c_div_dividend = '0;

        case (r_state)
            // one entry per cycle after reset
            S_CLEAR: begin
                c_wr_en = 1'b1;
                if (r_addr == BIN_W'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        KIND_DIRECT: begin
                            if (c_out_free) begin
                                o_pop                    = 1'b1;
                                n_out_vld                = 1'b1;
                                n_out_word.accepted      = 1'b0;
                                n_out_word.bin_hit       = '0;
                                n_out_word.peak_position = i_cmd.a;
                                n_out_word.count_value   = '0;
                            end
                        end
                        KIND_READ: begin
                            o_pop     = 1'b1;
                            c_rd_en   = 1'b1;
                            c_rd_addr = BIN_W'(i_cmd.sel);
                            n_state   = S_RD_OUT;
                        end
                        KIND_HIT: begin
                            o_pop = 1'b1;
                            if (i_cmd.a < i_cfg.bin_origin) begin
                                // underflow bin
                                c_rd_en   = 1'b1;
                                c_rd_addr = '0;
                                n_bin     = '0;
                                n_state   = S_EV_WR;
                            end else begin
                                c_div_start    = 1'b1;
                                c_div_dividend = i_cmd.a - i_cfg.bin_origin;
                                n_state        = S_EV_DIV;
                            end
                        end
                        KIND_PEAK: begin
                            o_pop  = 1'b1;
                            n_lo   = i_cmd.a;
                            n_hi   = i_cmd.b;
                            n_best = '0;
                            n_pos  = i_cmd.a;
                            if (i_cmd.a < i_cfg.bin_origin) begin
                                n_bin  = '0;
                                n_edge = i_cfg.bin_origin;
                                if (i_cmd.b < i_cfg.bin_origin) begin
                                    n_bhi   = '0;
                                    n_addr  = '0;
                                    n_first = 1'b1;
                                    n_state = S_PK_SCAN;
                                end else begin
                                    c_div_start    = 1'b1;
                                    c_div_dividend = i_cmd.b - i_cfg.bin_origin;
                                    n_state        = S_PK_HI;
                                end
                            end else begin
                                c_div_start    = 1'b1;
                                c_div_dividend = i_cmd.a - i_cfg.bin_origin;
                                n_state        = S_PK_LO;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_EV_DIV: begin
                if (w_div_done) begin
                    n_bin     = c_div_bin;
                    c_rd_en   = 1'b1;
                    c_rd_addr = c_div_bin;
                    n_state   = S_EV_WR;
                end
            end

            // saturating increment and result
            S_EV_WR: begin
                if (c_out_free) begin
                    c_wr_en   = 1'b1;
                    c_wr_addr = r_bin;
                    c_wr_data = (r_rd_data == '1) ? r_rd_data : r_rd_data + 1'b1;
                    n_out_vld                = 1'b1;
                    n_out_word.accepted      = 1'b1;
                    n_out_word.bin_hit       = HIT_W'(r_bin);
                    n_out_word.peak_position = '0;
                    n_out_word.count_value   = '0;
                    n_state                  = S_IDLE;
                end
            end

            S_RD_OUT: begin
                if (c_out_free) begin
                    n_out_vld                = 1'b1;
                    n_out_word.accepted      = 1'b0;
                    n_out_word.bin_hit       = '0;
                    n_out_word.peak_position = '0;
                    n_out_word.count_value   = r_rd_data;
                    n_state                  = S_IDLE;
                end
            end

            // low edge of the bin after the first: lo - rem + width
            S_PK_LO: begin
                if (w_div_done) begin
                    n_bin          = c_div_bin;
                    n_edge         = r_lo - HEIGHT_W'(w_div_rem) + HEIGHT_W'(c_width);
                    c_div_start    = 1'b1;
                    c_div_dividend = r_hi - i_cfg.bin_origin;
                    n_state        = S_PK_HI;
                end
            end

            S_PK_HI: begin
                if (w_div_done) begin
                    n_bhi   = c_div_bin;
                    n_addr  = r_bin;
                    n_first = 1'b1;
                    n_state = S_PK_SCAN;
                end
            end

            // one bin read per cycle, edge advances by the width
            S_PK_SCAN: begin
                c_rd_en      = 1'b1;
                c_rd_addr    = r_addr;
                n_pipe_vld   = 1'b1;
                n_pipe_first = r_first;
                n_pipe_edge  = r_edge;
                n_first      = 1'b0;
                if (!r_first) begin
                    n_edge = r_edge + HEIGHT_W'(c_width);
                end
                if (r_addr == r_bhi) begin
                    n_state = S_PK_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            S_PK_DONE: begin
                if (c_out_free) begin
                    n_out_vld                = 1'b1;
                    n_out_word.accepted      = 1'b0;
                    n_out_word.bin_hit       = '0;
                    n_out_word.peak_position = c_cmp_pos;
                    n_out_word.count_value   = c_cmp_best;
                    n_state                  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_pipe_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_pipe_vld <= n_pipe_vld;
            r_out_vld  <= n_out_vld;
        end
        r_bin        <= n_bin;
        r_bhi        <= n_bhi;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_edge       <= n_edge;
        r_pos        <= n_pos;
        r_best       <= n_best;
        r_first      <= n_first;
        r_pipe_first <= n_pipe_first;
        r_pipe_edge  <= n_pipe_edge;
        r_out_word   <= n_out_word;
    end

    // Memory write port
    always_ff @(posedge i_clk) begin
        if (c_wr_en) begin
            r_mem[c_wr_addr] <= c_wr_data;
        end
    end

    // Memory read port, registered
    always_ff @(posedge i_clk) begin
        if (c_rd_en) begin
            r_rd_data <= r_mem[c_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/graded_event_spectrum_accumulator.sv
// ----------------------------------------------------------------------------
// graded_event_spectrum_accumulator: pulse-height spectrum builder
// Window and grade filter for detector events, saturating bin counters,
// peak search over a height range and single bin reads.
//
//   channel   direction  handshake                 payload
//   ------    ---------  ------------------------  -----------------------
//   in        in         i_in_valid / o_in_ready   i_in_word  (t_in_word)
//   out       out        o_out_valid / i_out_ready o_out_word (t_out_word)
//   cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Event: an accepted height, less the origin, is divided by the bin width
// (4 quotient bits per cycle), then its bin count is read, bumped and
// written back; an underflow event skips the divide. Read bin: a
// registered memory read. Filtered or out-of-range words are answered
// from the queue head. Peak search: a divide per range end at or above the
// origin, then a scan of the bins in range. After reset all NUM_BINS + 2
// memory entries are cleared; no word is taken meanwhile. A two-entry
// queue and the result register let input words in while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module graded_event_spectrum_accumulator #(
    parameter int NUM_BINS = gesa_pkg::NUM_BINS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire gesa_pkg::t_in_word             i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output gesa_pkg::t_out_word                 o_out_word,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gesa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gesa_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import gesa_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_pop;
    t_cmd w_head_cmd;
    logic w_fifo_valid;
    logic w_fifo_full;
    logic w_clearing;

    // Configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height_min <= '0;
            r_cfg.height_max <= '1;
            r_cfg.grade_mode <= GRADE_GOOD;
            r_cfg.bin_origin <= '0;
            r_cfg.bin_width  <= WIDTH_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HEIGHT_MIN: r_cfg.height_min <= HEIGHT_W'(i_cfg_data);
                CFG_HEIGHT_MAX: r_cfg.height_max <= HEIGHT_W'(i_cfg_data);
                CFG_GRADE_MODE: r_cfg.grade_mode <= GRADE_W'(i_cfg_data);
                CFG_BIN_ORIGIN: r_cfg.bin_origin <= HEIGHT_W'(i_cfg_data);
                CFG_BIN_WIDTH:  r_cfg.bin_width  <= WIDTH_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    gesa_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_ready  (o_in_ready),
        .i_cfg       (r_cfg),
        .i_fifo_full (w_fifo_full),
        .i_clearing  (w_clearing),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    gesa_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_valid (w_fifo_valid),
        .o_full  (w_fifo_full)
    );

    gesa_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_fifo_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/gesa_checker.sv
// ----------------------------------------------------------------------------
// gesa_checker: port-level checks for the spectrum accumulator
// Result hold under stall, field consistency of result words, and the
// input hold-off during the post-reset memory clear.
// ----------------------------------------------------------------------------
`default_nettype none

module gesa_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire gesa_pkg::t_out_word o_out_word
);
    import gesa_pkg::*;

    // Stalled result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stalled result word does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("result word changed while stalled");

    // Rejected or non-event words never report a bin
    a_hit_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.accepted |-> o_out_word.bin_hit == '0)
        else $error("bin reported without acceptance");

    // An accepted event carries no position and no count
    a_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.accepted |->
            o_out_word.peak_position == '0 && o_out_word.count_value == '0)
        else $error("event result carries peak fields");

    // No word taken right after reset while the store is cleared
    a_clear_holdoff: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input taken during memory clear");

endmodule

bind graded_event_spectrum_accumulator gesa_checker u_gesa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
